### rtl/bg_tilemap_fetch_address_assert.svh
// Assertion macros for the background tilemap fetch address block.
// Users must have clk_i and rst_ni in scope where the macros are expanded.
`ifndef BG_TILEMAP_FETCH_ADDRESS_ASSERT_SVH
`define BG_TILEMAP_FETCH_ADDRESS_ASSERT_SVH

// Checked on every rising edge, switched off while reset is held.
`define BGTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BGTF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/bgtf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the background tilemap fetch address block.
// Used by every module of the block; depends on nothing else.
package bgtf_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CFG_MAP_BASE  = 3'd0,
    CFG_CHAR_BASE = 3'd1,
    CFG_SCROLL_X  = 3'd2,
    CFG_SCROLL_Y  = 3'd3,
    CFG_MAP_WIDE  = 3'd4,
    CFG_MAP_TALL  = 3'd5,
    CFG_WANT_HIGH = 3'd6,
    CFG_LAYER_ON  = 3'd7
  } cfg_idx_e;

  localparam int unsigned AddrW = 15;
  localparam int unsigned DataW = 16;
  localparam int unsigned CfgDataW = 15;

  // Screen offsets inside a multi-screen tilemap.
  localparam logic [AddrW-1:0] ScreenOfs    = 15'h400;
  localparam logic [AddrW-1:0] TallWideOfs  = 15'h800;

  typedef struct packed {
    logic [AddrW-1:0] map_base;
    logic [AddrW-1:0] char_base;
    logic [9:0]       scroll_x;
    logic [9:0]       scroll_y;
    logic             map_wide;
    logic             map_tall;
    logic             want_high;
    logic             layer_on;
  } cfg_t;

  // One item in flight: a memory write or a fetch with its fine position.
  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] addr;
    logic [2:0]       fine_x;
    logic [2:0]       fine_y;
    logic [DataW-1:0] data;
  } item_t;

  typedef struct packed {
    logic             visible;
    logic [AddrW-1:0] entry_addr;
    logic [AddrW-1:0] tile_addr;
    logic [2:0]       palette_num;
    logic [2:0]       col_in_tile;
    logic [2:0]       row_in_tile;
    logic             flip_h;
    logic             flip_v;
  } res_t;

endpackage

### rtl/bgtf_addr.sv
`timescale 1ns / 1ps
// Address stage: applies scroll and forms the tilemap entry word address.
// Depends on bgtf_pkg.
module bgtf_addr (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  bgtf_pkg::cfg_t     cfg_i,
  input  logic               valid_i,
  input  bgtf_pkg::op_e      op_i,
  input  logic [7:0]         pixel_x_i,
  input  logic [7:0]         pixel_y_i,
  input  logic [14:0]        mem_addr_i,
  input  logic [15:0]        mem_data_i,
  output logic               valid_o,
  output bgtf_pkg::item_t    item_o
);
  import bgtf_pkg::*;

  logic [8:0]       xs, ys;
  logic [AddrW-1:0] tall_ofs, wide_ofs, entry_addr;
  logic             valid_q;
  item_t            item_d, item_q;

  always_comb begin
    xs = 9'({1'b0, pixel_x_i} + cfg_i.scroll_x[8:0]);
    ys = 9'({1'b0, pixel_y_i} + cfg_i.scroll_y[8:0]);
    tall_ofs = '0;
    if (ys[8] && cfg_i.map_tall) begin
      tall_ofs = cfg_i.map_wide ? TallWideOfs : ScreenOfs;
    end
    wide_ofs = (xs[8] && cfg_i.map_wide) ? ScreenOfs : '0;
    entry_addr = cfg_i.map_base + {5'b0, ys[7:3], 5'b0} + tall_ofs + wide_ofs
                 + {10'b0, xs[7:3]};

    item_d.op     = op_i;
    item_d.addr   = (op_i == OP_FETCH) ? entry_addr : mem_addr_i;
    item_d.fine_x = xs[2:0];
    item_d.fine_y = ys[2:0];
    item_d.data   = mem_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/bgtf_vram.sv
`timescale 1ns / 1ps
// Video memory: reduces the word address modulo the memory size, then
// writes or reads the memory with registered read data. Depends on bgtf_pkg.
module bgtf_vram #(
  parameter int unsigned MEM_WORDS = 32768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  bgtf_pkg::item_t    item_i,
  output logic               valid_o,
  output bgtf_pkg::item_t    item_o,
  output logic [15:0]        rdata_o
);
  import bgtf_pkg::*;

  localparam int unsigned IdxW = $clog2(MEM_WORDS);
  localparam int unsigned QMax = 32767 / MEM_WORDS;
  localparam int unsigned QW   = $clog2(QMax + 2);
  // Rounded-up reciprocal; exact floor for 15-bit addresses and sizes below 2^17.
  localparam logic [32:0] Recip =
    33'(((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));

  logic [47:0]      prod;
  logic [QW-1:0]    quot_d, quot_q;
  logic [16:0]      diff;
  logic [IdxW-1:0]  idx;
  logic             s3_valid_q, s4_valid_q;
  item_t            s3_item_q, s4_item_q;
  logic [DataW-1:0] rdata_q;
  logic [DataW-1:0] vram_q [MEM_WORDS];

  assign prod   = 48'(item_i.addr) * 48'(Recip);
  assign quot_d = prod[32 +: QW];

  // The quotient is at most 32767 / MEM_WORDS, so its product with the size fits in 17 bits.
  assign diff = 17'(s3_item_q.addr) - 17'(17'(quot_q) * 17'(MEM_WORDS));
  assign idx  = diff[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv_i) begin
      s3_valid_q <= valid_i;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      quot_q    <= quot_d;
      s3_item_q <= item_i;
      s4_item_q <= s3_item_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s3_valid_q && s3_item_q.op == OP_WRITE) begin
      vram_q[idx] <= s3_item_q.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rdata_q <= vram_q[idx];
    end
  end

  assign valid_o = s4_valid_q;
  assign item_o  = s4_item_q;
  assign rdata_o = rdata_q;

endmodule

### rtl/bgtf_decode.sv
`timescale 1ns / 1ps
// Entry decode and output register: tile address, flips, palette, visibility.
// Depends on bgtf_pkg.
module bgtf_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  bgtf_pkg::cfg_t     cfg_i,
  input  logic               valid_i,
  input  bgtf_pkg::item_t    item_i,
  input  logic [15:0]        entry_i,
  output logic               valid_o,
  output bgtf_pkg::res_t     res_o
);
  import bgtf_pkg::*;

  logic valid_q;
  res_t res_d, res_q;

  always_comb begin
    res_d.flip_h      = entry_i[14];
    res_d.flip_v      = entry_i[15];
    res_d.palette_num = entry_i[12:10];
    res_d.entry_addr  = item_i.addr;
    res_d.tile_addr   = cfg_i.char_base + {1'b0, entry_i[9:0], 4'b0};
    // Seven minus a three-bit value is its complement.
    res_d.col_in_tile = item_i.fine_x ^ {3{entry_i[14]}};
    res_d.row_in_tile = item_i.fine_y ^ {3{entry_i[15]}};
    res_d.visible     = cfg_i.layer_on && (entry_i[13] == cfg_i.want_high);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i && (item_i.op == OP_FETCH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### rtl/bg_tilemap_fetch_address.sv
`timescale 1ns / 1ps
// Background tilemap fetch address unit, top level.
// Input beats either write one video memory word (operation 0) or fetch the
// tilemap entry for a screen pixel (operation 1); only fetches produce an
// output beat. Both channels use valid/stall; a beat moves when valid is high
// and stall is low. Registers are written over the cfg channel (valid/ready,
// always ready) and must only change while the block is idle.
// The pipeline has five register stages: input, scroll and map address,
// address reduction modulo the memory size, memory read, and decode.
// One beat is accepted per cycle while the receiver does not stall a result;
// the single-port memory access per item sets that rate.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and the configuration registers to zero. Memory contents are
// undefined until written; no clearing pass is run.
// Depends on bgtf_pkg, bgtf_addr, bgtf_vram and bgtf_decode.
`include "bg_tilemap_fetch_address_assert.svh"
module bg_tilemap_fetch_address #(
  parameter int unsigned MEM_WORDS = 32768
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [14:0]  cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic         operation_i,
  input  logic [7:0]   pixel_x_i,
  input  logic [7:0]   pixel_y_i,
  input  logic [14:0]  mem_addr_i,
  input  logic [15:0]  mem_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         visible_o,
  output logic [14:0]  entry_addr_o,
  output logic [14:0]  tile_addr_o,
  output logic [2:0]   palette_num_o,
  output logic [2:0]   col_in_tile_o,
  output logic [2:0]   row_in_tile_o,
  output logic         flip_h_o,
  output logic         flip_v_o
);
  import bgtf_pkg::*;

  cfg_t             cfg_q;
  logic             adv;
  logic             s1_valid_q;
  op_e              s1_op_q;
  logic [7:0]       s1_px_q, s1_py_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [DataW-1:0] s1_data_q;
  logic             s2_valid;
  item_t            s2_item;
  logic             vram_valid;
  item_t            vram_item;
  logic [DataW-1:0] vram_rdata;
  logic             res_valid;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAP_BASE:  cfg_q.map_base  <= cfg_data_i;
        CFG_CHAR_BASE: cfg_q.char_base <= cfg_data_i;
        CFG_SCROLL_X:  cfg_q.scroll_x  <= cfg_data_i[9:0];
        CFG_SCROLL_Y:  cfg_q.scroll_y  <= cfg_data_i[9:0];
        CFG_MAP_WIDE:  cfg_q.map_wide  <= cfg_data_i[0];
        CFG_MAP_TALL:  cfg_q.map_tall  <= cfg_data_i[0];
        CFG_WANT_HIGH: cfg_q.want_high <= cfg_data_i[0];
        CFG_LAYER_ON:  cfg_q.layer_on  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // All stages move together unless a finished result is held by the receiver.
  assign adv        = !(res_valid && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q   <= op_e'(operation_i);
      s1_px_q   <= pixel_x_i;
      s1_py_q   <= pixel_y_i;
      s1_addr_q <= mem_addr_i;
      s1_data_q <= mem_data_i;
    end
  end

  bgtf_addr u_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .cfg_i      (cfg_q),
    .valid_i    (s1_valid_q),
    .op_i       (s1_op_q),
    .pixel_x_i  (s1_px_q),
    .pixel_y_i  (s1_py_q),
    .mem_addr_i (s1_addr_q),
    .mem_data_i (s1_data_q),
    .valid_o    (s2_valid),
    .item_o     (s2_item)
  );

  bgtf_vram #(
    .MEM_WORDS (MEM_WORDS)
  ) u_vram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s2_valid),
    .item_i  (s2_item),
    .valid_o (vram_valid),
    .item_o  (vram_item),
    .rdata_o (vram_rdata)
  );

  bgtf_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cfg_i   (cfg_q),
    .valid_i (vram_valid),
    .item_i  (vram_item),
    .entry_i (vram_rdata),
    .valid_o (res_valid),
    .res_o   (res)
  );

  assign out_valid_o   = res_valid;
  assign visible_o     = res.visible;
  assign entry_addr_o  = res.entry_addr;
  assign tile_addr_o   = res.tile_addr;
  assign palette_num_o = res.palette_num;
  assign col_in_tile_o = res.col_in_tile;
  assign row_in_tile_o = res.row_in_tile;
  assign flip_h_o      = res.flip_h;
  assign flip_v_o      = res.flip_v;

  // A stalled input side means the input, address and memory stages held their valid bits.
  `BGTF_ASSERT(a_hold_on_stall, in_stall_o |=> $stable(s1_valid_q) && $stable(s2_valid) && $stable(vram_valid), "pipeline moved while stalled")
  // A new result only comes from a fetch that sat in the memory read stage.
  `BGTF_ASSERT(a_result_from_fetch, $rose(out_valid_o) |-> $past(vram_valid && vram_item.op == OP_FETCH), "result without a fetch")
  `BGTF_ASSERT_RST(a_reset_quiet, !rst_ni |-> !out_valid_o && !in_stall_o, "activity during reset")

endmodule

### sim/bg_tilemap_fetch_address_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the background tilemap fetch address block.
// Needs bgtf_pkg and the block's RTL; drives write and fetch beats, predicts each fetch.
module bg_tilemap_fetch_address_test;
  import bgtf_pkg::*;

  localparam int unsigned MemWords      = 32768;
  localparam int unsigned RandPhases    = 9;
  localparam int unsigned ItemsPerPhase = 112;
  localparam int unsigned HoldPhase     = 1;
  localparam int unsigned PausePhase    = 2;
  localparam int unsigned CalmPhase     = 4;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned QuietCycles   = 10;
  localparam longint unsigned TimeLimitNs = 64'd10_000_000;

  // Screen offsets within a multi-screen map, in words.
  localparam logic [14:0] ScreenStep = 15'h400;
  localparam logic [14:0] QuadStep   = 15'h800;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WRITE,
    ROW_FETCH
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [14:0] addr;
    logic [15:0] data;
    logic [7:0]  px;
    logic [7:0]  py;
    logic        typed;
    res_t        want;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [14:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        operation_i;
  logic [7:0]  pixel_x_i;
  logic [7:0]  pixel_y_i;
  logic [14:0] mem_addr_i;
  logic [15:0] mem_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        visible_o;
  logic [14:0] entry_addr_o;
  logic [14:0] tile_addr_o;
  logic [2:0]  palette_num_o;
  logic [2:0]  col_in_tile_o;
  logic [2:0]  row_in_tile_o;
  logic        flip_h_o;
  logic        flip_v_o;

  cfg_t        layer_cfg = '0;
  logic [15:0] vram_shadow [MemWords];
  bit          vram_written [MemWords];
  res_t        fetch_results_q [$];
  int unsigned mismatches = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_asked = 0;

  // Entries with the typed flag set carry a result read straight off the entry bits.
  plan_row_t plan [$] = '{
    '{ROW_WRITE, 15'h0000, 16'hffff, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 1'b1,
      '{1'b0, 15'h0000, 15'h3ff0, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1}},
    '{ROW_WRITE, 15'h03ff, 16'h0000, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd255, 8'd255, 1'b1,
      '{1'b0, 15'h03ff, 15'h0000, 3'd0, 3'd7, 3'd7, 1'b0, 1'b0}},
    '{ROW_CFG, 15'(CFG_LAYER_ON), 16'd1, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 1'b1,
      '{1'b0, 15'h0000, 15'h3ff0, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1}},
    '{ROW_CFG, 15'(CFG_WANT_HIGH), 16'd1, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 1'b1,
      '{1'b1, 15'h0000, 15'h3ff0, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1}},
    '{ROW_WRITE, 15'h0000, 16'h2000, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 1'b1,
      '{1'b1, 15'h0000, 15'h0000, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0}},
    '{ROW_WRITE, 15'h0000, 16'h1c00, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd3, 8'd5, 1'b1,
      '{1'b0, 15'h0000, 15'h0000, 3'd7, 3'd3, 3'd5, 1'b0, 1'b0}},
    '{ROW_CFG, 15'(CFG_CHAR_BASE), 16'h7fff, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_WRITE, 15'h0000, 16'h0001, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 1'b1,
      '{1'b0, 15'h0000, 15'h000f, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0}},
    '{ROW_CFG, 15'(CFG_SCROLL_X), 16'h03ff, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 15'(CFG_SCROLL_Y), 16'h03ff, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd1, 8'd1, 1'b1,
      '{1'b0, 15'h0000, 15'h000f, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0}},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 15'(CFG_MAP_WIDE), 16'd1, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 15'(CFG_MAP_TALL), 16'd1, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd255, 8'd0, 1'b0, '0},
    '{ROW_CFG, 15'(CFG_MAP_BASE), 16'h7fff, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 15'(CFG_MAP_WIDE), 16'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_WRITE, 15'h7fff, 16'hffff, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd1, 8'd1, 1'b0, '0},
    '{ROW_FETCH, 15'h0000, 16'h0000, 8'd255, 8'd128, 1'b0, '0}
  };

  bg_tilemap_fetch_address #(
    .MEM_WORDS(MemWords)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .mem_addr_i   (mem_addr_i),
    .mem_data_i   (mem_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .visible_o    (visible_o),
    .entry_addr_o (entry_addr_o),
    .tile_addr_o  (tile_addr_o),
    .palette_num_o(palette_num_o),
    .col_in_tile_o(col_in_tile_o),
    .row_in_tile_o(row_in_tile_o),
    .flip_h_o     (flip_h_o),
    .flip_v_o     (flip_v_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [8:0] scroll_pos(logic [7:0] p, logic [9:0] s);
    return 9'(p + s);
  endfunction

  function automatic logic [14:0] entry_word_addr(logic [7:0] px, logic [7:0] py);
    logic [8:0]  xs;
    logic [8:0]  ys;
    logic [14:0] a;
    xs = scroll_pos(px, layer_cfg.scroll_x);
    ys = scroll_pos(py, layer_cfg.scroll_y);
    a = layer_cfg.map_base + {ys[7:3], 5'b00000};
    if (ys[8] && layer_cfg.map_tall) begin
      a = a + (layer_cfg.map_wide ? QuadStep : ScreenStep);
    end
    if (xs[8] && layer_cfg.map_wide) begin
      a = a + ScreenStep;
    end
    return a + xs[7:3];
  endfunction

  function automatic res_t predict_fetch(logic [7:0] px, logic [7:0] py);
    res_t        r;
    logic [15:0] e;
    logic [8:0]  xs;
    logic [8:0]  ys;
    xs = scroll_pos(px, layer_cfg.scroll_x);
    ys = scroll_pos(py, layer_cfg.scroll_y);
    r.entry_addr  = entry_word_addr(px, py);
    e             = vram_shadow[r.entry_addr % MemWords];
    r.flip_h      = e[14];
    r.flip_v      = e[15];
    r.col_in_tile = e[14] ? ~xs[2:0] : xs[2:0];
    r.row_in_tile = e[15] ? ~ys[2:0] : ys[2:0];
    r.visible     = layer_cfg.layer_on && (e[13] == layer_cfg.want_high);
    r.tile_addr   = layer_cfg.char_base + {e[9:0], 4'b0000};
    r.palette_num = e[12:10];
    return r;
  endfunction

  function automatic logic [14:0] reg_value(cfg_idx_e idx, int unsigned phase);
    logic [14:0] top;
    case (idx)
      CFG_MAP_BASE, CFG_CHAR_BASE: top = 15'h7fff;
      CFG_SCROLL_X, CFG_SCROLL_Y:  top = 15'h03ff;
      default:                     top = 15'h0001;
    endcase
    if (phase == 0) return top;
    if (phase == 1) return '0;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return top;
      default: return 15'($urandom) & top;
    endcase
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Leaves cfg_valid_i high so that back-to-back writes need no re-raise.
  task automatic write_reg(cfg_idx_e idx, logic [14:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAP_BASE:  layer_cfg.map_base  = value;
      CFG_CHAR_BASE: layer_cfg.char_base = value;
      CFG_SCROLL_X:  layer_cfg.scroll_x  = value[9:0];
      CFG_SCROLL_Y:  layer_cfg.scroll_y  = value[9:0];
      CFG_MAP_WIDE:  layer_cfg.map_wide  = value[0];
      CFG_MAP_TALL:  layer_cfg.map_tall  = value[0];
      CFG_WANT_HIGH: layer_cfg.want_high = value[0];
      CFG_LAYER_ON:  layer_cfg.layer_on  = value[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_beat(op_e op, logic [7:0] px, logic [7:0] py, logic [14:0] addr,
                           logic [15:0] data, bit typed, res_t want);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    pixel_x_i   <= px;
    pixel_y_i   <= py;
    mem_addr_i  <= addr;
    mem_data_i  <= data;
    do @(posedge clk_i); while (in_stall_o);
    if (op == OP_WRITE) begin
      vram_shadow[addr % MemWords]  = data;
      vram_written[addr % MemWords] = 1'b1;
    end else begin
      fetch_results_q.push_back(typed ? want : predict_fetch(px, py));
    end
    @(negedge clk_i);
  endtask

  // A fetch never reads an entry that was never written, so fill it first if needed.
  task automatic fetch_pixel(logic [7:0] px, logic [7:0] py, bit typed, res_t want);
    logic [14:0] ea;
    ea = entry_word_addr(px, py);
    if (!vram_written[ea % MemWords]) begin
      send_beat(OP_WRITE, 8'($urandom), 8'($urandom), ea, 16'($urandom), 1'b0, '0);
    end
    send_beat(OP_FETCH, px, py, 15'($urandom), 16'($urandom), typed, want);
  endtask

  task automatic random_item();
    logic [7:0] px;
    logic [7:0] py;
    px = pick_pixel();
    py = pick_pixel();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: begin
        send_beat(OP_WRITE, px, py, 15'($urandom), 16'($urandom), 1'b0, '0);
      end
      5, 6, 7: begin
        send_beat(OP_WRITE, px, py, entry_word_addr(px, py), 16'($urandom), 1'b0, '0);
      end
      default: fetch_pixel(px, py, 1'b0, '0);
    endcase
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (fetch_results_q.size() != 0);
    @(negedge clk_i);
  endtask

  // Writes cause no result beat, so a quiet wait after the last result lets the last of them retire.
  task automatic drain_pipeline();
    wait_results();
    repeat (QuietCycles) @(negedge clk_i);
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (fetch_results_q.size() == 0) begin
      $error("result beat arrived with no fetch pending");
      mismatches++;
      return;
    end
    want = fetch_results_q.pop_front();
    if (got.visible !== want.visible) begin
      $error("visible: expected %0h, got %0h", want.visible, got.visible);
      mismatches++;
    end
    if (got.entry_addr !== want.entry_addr) begin
      $error("entry_addr: expected %0h, got %0h", want.entry_addr, got.entry_addr);
      mismatches++;
    end
    if (got.tile_addr !== want.tile_addr) begin
      $error("tile_addr: expected %0h, got %0h", want.tile_addr, got.tile_addr);
      mismatches++;
    end
    if (got.palette_num !== want.palette_num) begin
      $error("palette_num: expected %0h, got %0h", want.palette_num, got.palette_num);
      mismatches++;
    end
    if (got.col_in_tile !== want.col_in_tile) begin
      $error("col_in_tile: expected %0h, got %0h", want.col_in_tile, got.col_in_tile);
      mismatches++;
    end
    if (got.row_in_tile !== want.row_in_tile) begin
      $error("row_in_tile: expected %0h, got %0h", want.row_in_tile, got.row_in_tile);
      mismatches++;
    end
    if (got.flip_h !== want.flip_h) begin
      $error("flip_h: expected %0h, got %0h", want.flip_h, got.flip_h);
      mismatches++;
    end
    if (got.flip_v !== want.flip_v) begin
      $error("flip_v: expected %0h, got %0h", want.flip_v, got.flip_v);
      mismatches++;
    end
  endtask

  // Result beats are captured at the rising edge and checked at the falling edge that follows.
  initial begin : result_monitor
    res_t got;
    bit   fired;
    forever begin
      @(posedge clk_i);
      fired = out_valid_o && !out_stall_i;
      got = {visible_o, entry_addr_o, tile_addr_o, palette_num_o,
             col_in_tile_o, row_in_tile_o, flip_h_o, flip_v_o};
      @(negedge clk_i);
      if (fired) check_result(got);
    end
  end

  initial begin : result_sink
    bit          hold_now;
    bit          idle_now;
    int unsigned hold_taken;
    hold_taken  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      hold_now = (hold_asked != hold_taken);
      idle_now = idle_on && ($urandom_range(0, 5) == 0);
      @(negedge clk_i);
      if (hold_now) begin
        hold_taken++;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_now) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #(TimeLimitNs);
    $display("bg_tilemap_fetch_address_test failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    operation_i = 1'b0;
    pixel_x_i   = '0;
    pixel_y_i   = '0;
    mem_addr_i  = '0;
    mem_data_i  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          drain_pipeline();
          write_reg(cfg_idx_e'(plan[i].addr[2:0]), plan[i].data[14:0]);
          cfg_valid_i <= 1'b0;
        end
        ROW_WRITE: begin
          send_beat(OP_WRITE, 8'($urandom), 8'($urandom), plan[i].addr, plan[i].data,
                    1'b0, '0);
        end
        default: fetch_pixel(plan[i].px, plan[i].py, plan[i].typed, plan[i].want);
      endcase
    end

    for (int unsigned phase = 0; phase < RandPhases; phase++) begin
      drain_pipeline();
      idle_on = (phase != CalmPhase) && (phase != RandPhases - 1);
      for (int i = 0; i < 8; i++) begin
        write_reg(cfg_idx_e'(i), reg_value(cfg_idx_e'(i), phase));
      end
      cfg_valid_i <= 1'b0;
      // The sink holds off long enough for the pipeline to fill and push back.
      if (phase == HoldPhase) hold_asked++;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (phase == PausePhase && n == ItemsPerPhase / 2) wait_results();
        random_item();
      end
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("bg_tilemap_fetch_address_test passed");
    end else begin
      $display("bg_tilemap_fetch_address_test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/bgtf_pkg.sv
rtl/bgtf_addr.sv
rtl/bgtf_vram.sv
rtl/bgtf_decode.sv
rtl/bg_tilemap_fetch_address.sv
sim/bg_tilemap_fetch_address_test.sv
